[hw/rtl/cubemap_elevation_gradient_macros.svh]
// Assertion macros for the sky gradient block.
`ifndef CUBEMAP_ELEVATION_GRADIENT_MACROS_SVH
`define CUBEMAP_ELEVATION_GRADIENT_MACROS_SVH
`ifndef ASSERT_OFF
`define CEG_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cubemap_elevation_gradient: assertion failed");
`define CEG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cubemap_elevation_gradient: assertion failed");
`else
`define CEG_ASSERT_IMPL(lbl, ante, cons)
`define CEG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/ceg_pkg.sv]
package ceg_pkg;

   localparam int MAX_FACE_SIZE_DEF = 4096;
   localparam int FACE_SIZE_W       = 13;
   localparam int COLOR_W           = 24;
   localparam int QB                = 17;
   localparam int ONE_Q16           = 65536;
   localparam int HALF_Q16          = 32768;

   localparam logic [1:0] REG_FACE_SIZE = 2'd0;
   localparam logic [1:0] REG_ZENITH    = 2'd1;
   localparam logic [1:0] REG_HORIZON   = 2'd2;
   localparam logic [1:0] REG_NADIR     = 2'd3;

   localparam logic [FACE_SIZE_W-1:0] FACE_SIZE_RST = 13'd256;
   localparam logic [COLOR_W-1:0]     ZENITH_RST    = 24'h5896E2;
   localparam logic [COLOR_W-1:0]     HORIZON_RST   = 24'hECE0BE;
   localparam logic [COLOR_W-1:0]     NADIR_RST     = 24'h96784A;

   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;

endpackage

[hw/rtl/cubemap_elevation_gradient.sv]
// Throughput: one texel per cycle; the 58-stage pipe holds as a whole while
// a finished result waits on rsp_tready.
// Stages: 17 one-bit texel-center divide steps, 17 one-bit square-root steps
// and 17 one-bit elevation divide steps, plus select, square and blend stages.
// Reset: synchronous, clears all valid bits and loads the register defaults.
`include "cubemap_elevation_gradient_macros.svh"

module cubemap_elevation_gradient #(
   parameter int MAX_FACE_SIZE = ceg_pkg::MAX_FACE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // face[2:0], column[14:3], row[26:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int SZ_W = $clog2(MAX_FACE_SIZE + 1);
   localparam int CW   = (SZ_W > ceg_pkg::FACE_SIZE_W) ? SZ_W : ceg_pkg::FACE_SIZE_W;
   localparam int DW   = SZ_W + 1;
   localparam int QB   = ceg_pkg::QB;
   localparam int NS   = QB;
   localparam int S_SEL  = NS + 1;
   localparam int S_SQ   = S_SEL + 1;
   localparam int S_SUM  = S_SQ + 1;
   localparam int S_SQRT = S_SUM + NS;
   localparam int S_EDIV = S_SQRT + NS;
   localparam int S_P    = S_EDIV + 1;
   localparam int S_MUL  = S_P + 1;
   localparam int NST    = S_MUL + 2;

   logic [ceg_pkg::FACE_SIZE_W-1:0] face_size_ff;
   logic [ceg_pkg::COLOR_W-1:0]     zenith_ff, horizon_ff, nadir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= ceg_pkg::FACE_SIZE_RST;
         zenith_ff    <= ceg_pkg::ZENITH_RST;
         horizon_ff   <= ceg_pkg::HORIZON_RST;
         nadir_ff     <= ceg_pkg::NADIR_RST;
      end else if (csr_we) begin
         case (csr_index)
            ceg_pkg::REG_FACE_SIZE: face_size_ff <= csr_wdata[ceg_pkg::FACE_SIZE_W-1:0];
            ceg_pkg::REG_ZENITH:    zenith_ff    <= csr_wdata;
            ceg_pkg::REG_HORIZON:   horizon_ff   <= csr_wdata;
            ceg_pkg::REG_NADIR:     nadir_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic           adv;
   logic [NST-1:0] vld_ff;

   assign adv        = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   // effective size and clamped position
   logic [CW-1:0]   fs_ext, size_w, col_ext, row_ext, col_c, row_c;
   logic [SZ_W-1:0] size;

   always_comb begin
      fs_ext = CW'(face_size_ff);
      if (fs_ext == '0) begin
         size_w = CW'(1);
      end else if (fs_ext > CW'(MAX_FACE_SIZE)) begin
         size_w = CW'(MAX_FACE_SIZE);
      end else begin
         size_w = fs_ext;
      end
      size    = size_w[SZ_W-1:0];
      col_ext = CW'(req_tdata[14:3]);
      row_ext = CW'(req_tdata[26:15]);
      col_c   = (col_ext >= size_w) ? size_w - CW'(1) : col_ext;
      row_c   = (row_ext >= size_w) ? size_w - CW'(1) : row_ext;
   end

   // texel-center divide: (2p+1)/size, one quotient bit a stage
   logic [DW-1:0] cd_rx_ff [0:NS];
   logic [DW-1:0] cd_ry_ff [0:NS];
   logic [QB-1:0] cd_qx_ff [0:NS];
   logic [QB-1:0] cd_qy_ff [0:NS];
   logic [2:0]    cd_face_ff [0:NS];

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_rx_ff[0]   <= {col_c[SZ_W-1:0], 1'b1};
         cd_ry_ff[0]   <= {row_c[SZ_W-1:0], 1'b1};
         cd_qx_ff[0]   <= '0;
         cd_qy_ff[0]   <= '0;
         cd_face_ff[0] <= req_tdata[2:0];
      end
   end

   for (genvar j = 1; j <= NS; j++) begin : g_cdiv
      logic          gex, gey;
      logic [DW-1:0] sx, sy, rx_in, ry_in;
      always_comb begin
         gex   = cd_rx_ff[j-1] >= {1'b0, size};
         gey   = cd_ry_ff[j-1] >= {1'b0, size};
         sx    = gex ? cd_rx_ff[j-1] - {1'b0, size} : cd_rx_ff[j-1];
         sy    = gey ? cd_ry_ff[j-1] - {1'b0, size} : cd_ry_ff[j-1];
         rx_in = {sx[SZ_W-1:0], 1'b0};
         ry_in = {sy[SZ_W-1:0], 1'b0};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cd_rx_ff[j]   <= rx_in;
            cd_ry_ff[j]   <= ry_in;
            cd_qx_ff[j]   <= {cd_qx_ff[j-1][QB-2:0], gex};
            cd_qy_ff[j]   <= {cd_qy_ff[j-1][QB-2:0], gey};
            cd_face_ff[j] <= cd_face_ff[j-1];
         end
      end
   end

   // face table
   logic signed [17:0] uc, vc, dz_in, m1_in, m2_in;
   logic signed [17:0] sel_dz_ff, sel_m1_ff, sel_m2_ff;

   always_comb begin
      uc = $signed({1'b0, cd_qx_ff[NS]}) - 18'sd65536;
      vc = $signed({1'b0, cd_qy_ff[NS]}) - 18'sd65536;
      case (cd_face_ff[NS])
         ceg_pkg::FACE_POS_X: begin dz_in = -uc; m1_in = 18'sd65536; m2_in = vc; end
         ceg_pkg::FACE_NEG_X: begin dz_in = uc;  m1_in = 18'sd65536; m2_in = vc; end
         ceg_pkg::FACE_POS_Y: begin dz_in = vc;  m1_in = uc; m2_in = 18'sd65536; end
         ceg_pkg::FACE_NEG_Y: begin dz_in = -vc; m1_in = uc; m2_in = 18'sd65536; end
         ceg_pkg::FACE_POS_Z: begin dz_in = 18'sd65536;  m1_in = uc; m2_in = vc; end
         default:             begin dz_in = -18'sd65536; m1_in = uc; m2_in = vc; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel_dz_ff <= dz_in;
         sel_m1_ff <= m1_in;
         sel_m2_ff <= m2_in;
      end
   end

   // squares
   logic [16:0] a1, a2, a3;
   logic [33:0] sq1_ff, sq2_ff, sq3_ff;
   logic [16:0] sq_adz_ff;
   logic        sq_neg_ff;

   always_comb begin
      a1 = sel_m1_ff[17] ? 17'(-sel_m1_ff) : sel_m1_ff[16:0];
      a2 = sel_m2_ff[17] ? 17'(-sel_m2_ff) : sel_m2_ff[16:0];
      a3 = sel_dz_ff[17] ? 17'(-sel_dz_ff) : sel_dz_ff[16:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq1_ff    <= a1 * a1;
         sq2_ff    <= a2 * a2;
         sq3_ff    <= a3 * a3;
         sq_adz_ff <= a3;
         sq_neg_ff <= sel_dz_ff[17];
      end
   end

   // square root, one root bit a stage
   logic [33:0] sr_rem_ff  [0:NS];
   logic [16:0] sr_root_ff [0:NS];
   logic [16:0] sr_adz_ff  [0:NS];
   logic        sr_neg_ff  [0:NS];

   always_ff @(posedge clock) begin
      if (adv) begin
         sr_rem_ff[0]  <= sq1_ff + sq2_ff + sq3_ff;
         sr_root_ff[0] <= '0;
         sr_adz_ff[0]  <= sq_adz_ff;
         sr_neg_ff[0]  <= sq_neg_ff;
      end
   end

   for (genvar j = 1; j <= NS; j++) begin : g_sqrt
      localparam int B = NS - j;
      logic [34:0] trial;
      logic        ge;
      logic [34:0] diff;
      always_comb begin
         trial = (35'(sr_root_ff[j-1]) << (B + 1)) + (35'(1) << (2 * B));
         ge    = {1'b0, sr_rem_ff[j-1]} >= trial;
         diff  = {1'b0, sr_rem_ff[j-1]} - trial;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sr_rem_ff[j]  <= ge ? diff[33:0] : sr_rem_ff[j-1];
            sr_root_ff[j] <= ge ? (sr_root_ff[j-1] | (17'(1) << B)) : sr_root_ff[j-1];
            sr_adz_ff[j]  <= sr_adz_ff[j-1];
            sr_neg_ff[j]  <= sr_neg_ff[j-1];
         end
      end
   end

   // elevation divide: |dz| / len, one quotient bit a stage
   logic [17:0]   ed_r_ff   [1:NS];
   logic [QB-1:0] ed_q_ff   [1:NS];
   logic [16:0]   ed_len_ff [1:NS];
   logic          ed_neg_ff [1:NS];

   for (genvar j = 1; j <= NS; j++) begin : g_ediv
      logic [17:0]   r_p, s;
      logic [QB-1:0] q_p;
      logic [16:0]   d_p;
      logic          n_p, ge;
      if (j == 1) begin : g_seed
         assign r_p = {1'b0, sr_adz_ff[NS]};
         assign q_p = '0;
         assign d_p = sr_root_ff[NS];
         assign n_p = sr_neg_ff[NS];
      end else begin : g_chain
         assign r_p = ed_r_ff[j-1];
         assign q_p = ed_q_ff[j-1];
         assign d_p = ed_len_ff[j-1];
         assign n_p = ed_neg_ff[j-1];
      end
      always_comb begin
         ge = r_p >= {1'b0, d_p};
         s  = ge ? r_p - {1'b0, d_p} : r_p;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ed_r_ff[j]   <= {s[16:0], 1'b0};
            ed_q_ff[j]   <= {q_p[QB-2:0], ge};
            ed_len_ff[j] <= d_p;
            ed_neg_ff[j] <= n_p;
         end
      end
   end

   // elevation to blend weight
   logic [16:0] emag, p, t_in;
   logic [17:0] pm;
   logic        upper;
   logic [16:0] pt_t_ff;
   logic [ceg_pkg::COLOR_W-1:0] pt_a_ff, pt_b_ff;

   always_comb begin
      emag  = (ed_q_ff[NS] > 17'(ceg_pkg::ONE_Q16)) ? 17'(ceg_pkg::ONE_Q16) : ed_q_ff[NS];
      pm    = ed_neg_ff[NS] ? 18'(ceg_pkg::ONE_Q16) - {1'b0, emag}
                            : 18'(ceg_pkg::ONE_Q16) + {1'b0, emag};
      p     = pm[17:1];
      upper = p >= 17'(ceg_pkg::HALF_Q16);
      t_in  = upper ? 17'({p, 1'b0} - 18'(ceg_pkg::ONE_Q16)) : 17'({p, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_t_ff <= t_in;
         pt_a_ff <= upper ? horizon_ff : nadir_ff;
         pt_b_ff <= upper ? zenith_ff : horizon_ff;
      end
   end

   // blend: a*2^16 + (b-a)*t + half
   logic signed [26:0] mul_prod_ff [0:2];
   logic [7:0]         mul_a_ff    [0:2];
   logic [23:0]        out_ff;

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic        [7:0]  ca, cb;
      logic signed [8:0]  dif;
      logic signed [26:0] acc;
      always_comb begin
         ca  = pt_a_ff[8*c +: 8];
         cb  = pt_b_ff[8*c +: 8];
         dif = $signed({1'b0, cb}) - $signed({1'b0, ca});
         acc = $signed({3'b000, mul_a_ff[c], 16'h0000}) + mul_prod_ff[c] + 27'sd32768;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            mul_prod_ff[c]          <= 27'(dif * $signed({1'b0, pt_t_ff}));
            mul_a_ff[c]             <= ca;
            out_ff[8*(2-c) +: 8]    <= acc[23:16];
         end
      end
   end

   assign rsp_tdata = out_ff;

   `CEG_ASSERT_IMPL(a_stall_blocks_input, vld_ff[NST-1] && !rsp_tready, !req_tready)
   `CEG_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, vld_ff[0])
   `CEG_ASSERT_IMPL(a_len_at_least_one, vld_ff[S_SQRT], sr_root_ff[NS] >= 17'(ceg_pkg::ONE_Q16))
   `CEG_ASSERT_IMPL(a_elev_in_range, vld_ff[S_EDIV], ed_q_ff[NS] <= 17'(ceg_pkg::ONE_Q16))

endmodule
